// File: design/taa_pkg.sv
// Package for the tilt angle averager: field types, fixed-point constants
// and the CORDIC arctangent table. Depends on nothing.
package taa_pkg;

	localparam int ACCEL_W     = 20;
	localparam int TILT_W      = 16;
	localparam int ASUM_W      = 24;
	localparam int TSUM_W      = 20;
	localparam int DEV_W       = 32;
	localparam int CORDIC_ITER = 16;
	localparam int MAX_SAMPLES = 16;

	localparam logic [17:0] TILT_LIMIT = 18'd23040;
	localparam logic [20:0] DEV_SCALE  = 21'd1143819;

	// configuration register indexes
	localparam logic CFG_SAMPLES = 1'b0;
	localparam logic CFG_LEVER   = 1'b1;

	typedef logic signed [ACCEL_W-1:0] accel_t;
	typedef logic signed [TILT_W-1:0]  tilt_t;
	typedef logic signed [DEV_W-1:0]   dev_t;

	// atan(2^-i) in 1/65536 degree, rounded to nearest
	function automatic logic signed [25:0] atan_q16(input logic [3:0] i);
		logic signed [25:0] r;
		case (i)
			4'd0:  r = 26'sd2949120;
			4'd1:  r = 26'sd1740967;
			4'd2:  r = 26'sd919879;
			4'd3:  r = 26'sd466945;
			4'd4:  r = 26'sd234379;
			4'd5:  r = 26'sd117304;
			4'd6:  r = 26'sd58666;
			4'd7:  r = 26'sd29335;
			4'd8:  r = 26'sd14668;
			4'd9:  r = 26'sd7334;
			4'd10: r = 26'sd3667;
			4'd11: r = 26'sd1833;
			4'd12: r = 26'sd917;
			4'd13: r = 26'sd458;
			4'd14: r = 26'sd229;
			default: r = 26'sd115;
		endcase
		return r;
	endfunction

endpackage

// File: design/taa_tilt.sv
// Serial tilt unit: squares, a bit-pair square root and a vectoring CORDIC
// that gives atan2(a, sqrt(b^2 + c^2)) in 1/256 degree. Uses taa_pkg.
module taa_tilt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  taa_pkg::accel_t a,
	input  taa_pkg::accel_t b,
	input  taa_pkg::accel_t c,
	output logic           done,
	output taa_pkg::tilt_t tilt
);
	import taa_pkg::*;

	localparam logic [2:0] T_IDLE = 3'd0;
	localparam logic [2:0] T_SQ1  = 3'd1;
	localparam logic [2:0] T_SQ2  = 3'd2;
	localparam logic [2:0] T_ROOT = 3'd3;
	localparam logic [2:0] T_CHK  = 3'd4;
	localparam logic [2:0] T_CORD = 3'd5;
	localparam logic [2:0] T_FIN  = 3'd6;

	logic [2:0]         st_q;
	logic [4:0]         it_q;
	accel_t             a_q;
	logic [19:0]        bm_q, cm_q;
	logic [39:0]        sq_q;
	logic [23:0]        rem_q;
	logic [19:0]        root_q;
	logic signed [23:0] x_q, y_q;
	logic signed [25:0] z_q;
	logic               done_q;
	tilt_t              tilt_q;

	logic [23:0]        rem_n, trial;
	logic               take;
	logic signed [23:0] dx, dy;
	logic [25:0]        zabs;
	logic [17:0]        zr;
	logic [17:0]        zc;
	logic [19:0]        sq_op;
	logic [39:0]        sq_p;

	always_comb begin
		rem_n = {rem_q[21:0], sq_q[39:38]};
		trial = {2'b00, root_q, 2'b01};
		take  = (rem_n >= trial);
		dx    = y_q >>> it_q[3:0];
		dy    = x_q >>> it_q[3:0];
		zabs  = z_q[25] ? 26'(-z_q) : 26'(z_q);
		zr    = 18'((zabs + 26'd128) >> 8);
		zc    = (zr > TILT_LIMIT) ? TILT_LIMIT : zr;
		// one squarer, b in state T_SQ1 and c in state T_SQ2
		sq_op = (st_q == T_SQ1) ? bm_q : cm_q;
		sq_p  = sq_op * sq_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= T_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == T_CHK && (a_q == '0 || root_q == '0)) || st_q == T_FIN;
			unique case (st_q)
				T_IDLE: if (start) st_q <= T_SQ1;
				T_SQ1:  st_q <= T_SQ2;
				T_SQ2:  st_q <= T_ROOT;
				T_ROOT: if (it_q == 5'd19) st_q <= T_CHK;
				T_CHK: begin
					if (a_q == '0 || root_q == '0)
						st_q <= T_IDLE;
					else
						st_q <= T_CORD;
				end
				T_CORD: if (it_q == 5'(CORDIC_ITER - 1)) st_q <= T_FIN;
				T_FIN:  st_q <= T_IDLE;
				default: st_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			T_IDLE: begin
				a_q  <= a;
				bm_q <= b[19] ? 20'(-b) : 20'(b);
				cm_q <= c[19] ? 20'(-c) : 20'(c);
			end
			T_SQ1: sq_q <= sq_p;
			T_SQ2: begin
				sq_q   <= sq_q + sq_p;
				rem_q  <= '0;
				root_q <= '0;
				it_q   <= '0;
			end
			T_ROOT: begin
				sq_q   <= {sq_q[37:0], 2'b00};
				rem_q  <= take ? rem_n - trial : rem_n;
				root_q <= {root_q[18:0], take};
				it_q   <= it_q + 5'd1;
			end
			T_CHK: begin
				x_q  <= {4'd0, root_q};
				y_q  <= {{4{a_q[19]}}, a_q};
				z_q  <= '0;
				it_q <= '0;
				if (a_q == '0)
					tilt_q <= '0;
				else
					tilt_q <= a_q[19] ? -tilt_t'(TILT_LIMIT) : tilt_t'(TILT_LIMIT);
			end
			T_CORD: begin
				// rotate toward the x axis, steering by the sign of y
				if (!y_q[23]) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_q16(it_q[3:0]);
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_q16(it_q[3:0]);
				end
				it_q <= it_q + 5'd1;
			end
			T_FIN: tilt_q <= z_q[25] ? -tilt_t'(zc) : tilt_t'(zc);
			default: ;
		endcase
	end

	assign done = done_q;
	assign tilt = tilt_q;

endmodule

// File: design/tilt_angle_averager.sv
// Tilt angle averager: per-sample tilt of three axes, window sums, averages
// and lever deviations. Depends on taa_pkg and taa_tilt.
// One beat at a time: in_stall stays high from accept through the three axis tilts
// (a tilt ends early if its axis is zero or its other axes are flat).
// A window-closing sample adds the deviations, six serial divides and emit,
// plus output stall. Reset clears sums, count, handshakes; window 10, lever 500.
module tilt_angle_averager (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  taa_pkg::accel_t accel_x,
	input  taa_pkg::accel_t accel_y,
	input  taa_pkg::accel_t accel_z,
	output logic            out_valid,
	input  logic            out_stall,
	output taa_pkg::accel_t avg_accel_x,
	output taa_pkg::accel_t avg_accel_y,
	output taa_pkg::accel_t avg_accel_z,
	output taa_pkg::tilt_t  avg_tilt_x,
	output taa_pkg::tilt_t  avg_tilt_y,
	output taa_pkg::tilt_t  avg_tilt_z,
	output taa_pkg::dev_t   deviation_x,
	output taa_pkg::dev_t   deviation_y,
	output taa_pkg::dev_t   deviation_z
);
	import taa_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TILT = 4'd1;
	localparam logic [3:0] S_ACC  = 4'd2;
	localparam logic [3:0] S_DV1  = 4'd3;
	localparam logic [3:0] S_DV2  = 4'd4;
	localparam logic [3:0] S_DV3  = 4'd5;
	localparam logic [3:0] S_DV4  = 4'd6;
	localparam logic [3:0] S_DIVL = 4'd7;
	localparam logic [3:0] S_DIVS = 4'd8;
	localparam logic [3:0] S_DIVE = 4'd9;
	localparam logic [3:0] S_EMIT = 4'd10;

	logic [3:0]  st_q;
	logic [4:0]  samples_q;
	logic [15:0] lever_q;
	logic [4:0]  count_q;
	logic [1:0]  k_q;
	logic [2:0]  j_q;
	logic [4:0]  it_q;
	logic        start_q;
	logic        out_valid_q;

	accel_t                    smp_q [3];
	logic signed [ASUM_W-1:0]  asum_q [3];
	logic signed [TSUM_W-1:0]  tsum_q [3];
	dev_t                      dev_q [3];
	logic [ASUM_W-1:0]         quot_q [6];
	logic [35:0]               p_q;
	logic [57:0]               m_q;
	logic [ASUM_W-1:0]         dq_q;
	logic [4:0]                drem_q;
	logic                      neg_q;

	accel_t o_ax_q, o_ay_q, o_az_q;
	tilt_t  o_tx_q, o_ty_q, o_tz_q;
	dev_t   o_dx_q, o_dy_q, o_dz_q;

	accel_t                   ta, tb, tc;
	logic                     t_done;
	tilt_t                    t_val;
	logic [4:0]               n_eff;
	logic                     accept;
	logic signed [TSUM_W-1:0] tk;
	logic [TSUM_W-1:0]        tmag;
	logic [20:0]              mul_a, mul_b;
	logic [41:0]              mul_p;
	logic [57:0]              rnd;
	logic [33:0]              q;
	logic signed [ASUM_W-1:0] dval;
	logic [5:0]               rn;
	logic                     ge;

	always_comb begin
		// axis k tilts against the other two
		ta = smp_q[k_q];
		tb = (k_q == 2'd0) ? smp_q[1] : smp_q[0];
		tc = (k_q == 2'd2) ? smp_q[1] : smp_q[2];

		if (samples_q == '0)
			n_eff = 5'd1;
		else if (samples_q > 5'(MAX_SAMPLES))
			n_eff = 5'(MAX_SAMPLES);
		else
			n_eff = samples_q;

		accept = in_valid && !in_stall;

		tk   = tsum_q[k_q];
		tmag = tk[TSUM_W-1] ? TSUM_W'(-tk) : TSUM_W'(tk);

		// one multiplier: lever times |tilt sum|, then the scale in two halves
		if (st_q == S_DV1) begin
			mul_a = {5'd0, lever_q};
			mul_b = {1'b0, tmag};
		end else begin
			mul_a = {3'd0, (st_q == S_DV2) ? p_q[17:0] : p_q[35:18]};
			mul_b = DEV_SCALE;
		end
		mul_p = mul_a * mul_b;

		rnd  = m_q + 58'(1 << 23);
		q    = rnd[57:24];

		dval = (j_q < 3'd3) ? asum_q[j_q[1:0]]
		                    : {{(ASUM_W-TSUM_W){tsum_q[j_q[1:0] - 2'd3][TSUM_W-1]}},
		                       tsum_q[j_q[1:0] - 2'd3]};
		rn = {drem_q, dq_q[ASUM_W-1]};
		ge = (rn >= {1'b0, n_eff});
	end

	assign in_stall = (st_q != S_IDLE);

	taa_tilt u_tilt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.a      (ta),
		.b      (tb),
		.c      (tc),
		.done   (t_done),
		.tilt   (t_val)
	);

	// control: sequencer, registers, window sums and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			samples_q   <= 5'd10;
			lever_q     <= 16'd500;
			count_q     <= '0;
			k_q         <= '0;
			j_q         <= '0;
			it_q        <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				asum_q[i] <= '0;
				tsum_q[i] <= '0;
			end
		end else begin
			// kick the tilt unit on accept and after each axis but the last
			start_q <= (st_q == S_IDLE && accept)
				|| (st_q == S_TILT && t_done && k_q != 2'd2);
			if (cfg_we) begin
				if (cfg_index == CFG_SAMPLES)
					samples_q <= cfg_data[4:0];
				else
					lever_q <= cfg_data;
			end
			// raise valid on emit, drop it once the beat is taken
			if (st_q == S_EMIT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						k_q  <= '0;
						st_q <= S_TILT;
					end
				end
				S_TILT: begin
					if (t_done) begin
						tsum_q[k_q] <= tsum_q[k_q] + {{(TSUM_W-TILT_W){t_val[TILT_W-1]}}, t_val};
						if (k_q == 2'd2)
							st_q <= S_ACC;
						else
							k_q <= k_q + 2'd1;
					end
				end
				S_ACC: begin
					for (int i = 0; i < 3; i++)
						asum_q[i] <= asum_q[i]
							+ {{(ASUM_W-ACCEL_W){smp_q[i][ACCEL_W-1]}}, smp_q[i]};
					count_q <= count_q + 5'd1;
					k_q     <= '0;
					st_q    <= (count_q + 5'd1 >= n_eff) ? S_DV1 : S_IDLE;
				end
				S_DV1: st_q <= S_DV2;
				S_DV2: st_q <= S_DV3;
				S_DV3: st_q <= S_DV4;
				S_DV4: begin
					if (k_q == 2'd2) begin
						j_q  <= '0;
						st_q <= S_DIVL;
					end else begin
						k_q  <= k_q + 2'd1;
						st_q <= S_DV1;
					end
				end
				S_DIVL: begin
					it_q <= '0;
					st_q <= S_DIVS;
				end
				S_DIVS: begin
					it_q <= it_q + 5'd1;
					if (it_q == 5'(ASUM_W - 1))
						st_q <= S_DIVE;
				end
				S_DIVE: begin
					if (j_q == 3'd5) begin
						st_q <= S_EMIT;
					end else begin
						j_q  <= j_q + 3'd1;
						st_q <= S_DIVL;
					end
				end
				S_EMIT: begin
					// hold until the previous result has left
					if (!out_valid_q || !out_stall) begin
						count_q <= '0;
						for (int i = 0; i < 3; i++) begin
							asum_q[i] <= '0;
							tsum_q[i] <= '0;
						end
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath: sample capture, deviation multiply, serial divider
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && accept) begin
			smp_q[0] <= accel_x;
			smp_q[1] <= accel_y;
			smp_q[2] <= accel_z;
		end
		case (st_q)
			S_DV1: p_q <= mul_p[35:0];
			S_DV2: m_q <= {16'd0, mul_p};
			S_DV3: m_q <= m_q + {1'b0, mul_p[38:0], 18'd0};
			S_DV4: begin
				// saturate to 32-bit signed, sign taken from the tilt sum
				if (tk[TSUM_W-1])
					dev_q[k_q] <= (q > 34'h080000000) ? dev_t'(32'h80000000)
					                                  : dev_t'(-q[31:0]);
				else
					dev_q[k_q] <= (q > 34'h07FFFFFFF) ? dev_t'(32'h7FFFFFFF)
					                                  : dev_t'(q[31:0]);
			end
			S_DIVL: begin
				neg_q  <= dval[ASUM_W-1];
				dq_q   <= dval[ASUM_W-1] ? ASUM_W'(-dval) : ASUM_W'(dval);
				drem_q <= '0;
			end
			S_DIVS: begin
				drem_q <= ge ? 5'(rn - {1'b0, n_eff}) : rn[4:0];
				dq_q   <= {dq_q[ASUM_W-2:0], ge};
			end
			S_DIVE: quot_q[j_q] <= neg_q ? ASUM_W'(-dq_q) : dq_q;
			S_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					o_ax_q <= accel_t'(quot_q[0][ACCEL_W-1:0]);
					o_ay_q <= accel_t'(quot_q[1][ACCEL_W-1:0]);
					o_az_q <= accel_t'(quot_q[2][ACCEL_W-1:0]);
					o_tx_q <= tilt_t'(quot_q[3][TILT_W-1:0]);
					o_ty_q <= tilt_t'(quot_q[4][TILT_W-1:0]);
					o_tz_q <= tilt_t'(quot_q[5][TILT_W-1:0]);
					o_dx_q <= dev_q[0];
					o_dy_q <= dev_q[1];
					o_dz_q <= dev_q[2];
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign avg_accel_x = o_ax_q;
	assign avg_accel_y = o_ay_q;
	assign avg_accel_z = o_az_q;
	assign avg_tilt_x  = o_tx_q;
	assign avg_tilt_y  = o_ty_q;
	assign avg_tilt_z  = o_tz_q;
	assign deviation_x = o_dx_q;
	assign deviation_y = o_dy_q;
	assign deviation_z = o_dz_q;

endmodule

// File: tb/sv/tilt_angle_averager_tb.sv
// Self-checking bench for the tilt angle averager: directed samples, then
// random windows under several settings. Depends on taa_pkg and the block.
module tilt_angle_averager_tb;
	import taa_pkg::*;

	// block is busy after a sample that closes no window while it tilts the three axes
	localparam int SETTLE_CYCLES = 400;
	localparam int IDLE_LIMIT    = 20000;
	localparam int HOLD_CYCLES   = 3000;
	localparam int RANDOM_ITEMS  = 1760;

	typedef enum logic [1:0] {ROW_SAMPLE, ROW_CHECKED, ROW_CFG} row_kind_e;

	typedef struct {
		logic signed [19:0] acc [3];
		logic signed [15:0] tilt [3];
		logic signed [31:0] dev [3];
	} window_result_t;

	typedef struct {
		row_kind_e      kind;
		accel_t         x, y, z;
		logic           reg_idx;
		logic [15:0]    reg_val;
		window_result_t typed;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	accel_t accel_x = '0, accel_y = '0, accel_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	accel_t avg_accel_x, avg_accel_y, avg_accel_z;
	tilt_t avg_tilt_x, avg_tilt_y, avg_tilt_z;
	dev_t deviation_x, deviation_y, deviation_z;

	tilt_angle_averager uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state, mirrors the block after reset
	logic [4:0]  win_len = 5'd10;
	logic [15:0] lever_mm = 16'd500;
	int          win_count = 0;
	longint      acc_sum [3] = '{0, 0, 0};
	longint      tilt_sum [3] = '{0, 0, 0};

	window_result_t pending_windows[$];
	int  mismatches = 0;
	int  samples_sent = 0;
	int  windows_seen = 0;
	int  idle_cycles = 0;
	bit  idling_on = 1'b1;
	bit  long_hold = 1'b0;

	// atan(2^-i), 1/65536 degree
	const longint ATAN_STEP [16] = '{2949120, 1740967, 919879, 466945, 234379,
		117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// vectoring CORDIC on (|bc|, a), angle in 1/256 degree
	function automatic longint axis_tilt(longint a, longint b, longint c);
		longint unsigned mb, mc, len, zm;
		longint xv, yv, ang, dx, dy, r;
		mb = magnitude(b);
		mc = magnitude(c);
		len = floor_sqrt(mb * mb + mc * mc);
		if (a == 0)
			return 0;
		if (len == 0)
			return (a > 0) ? 23040 : -23040;
		xv = len;
		yv = a;
		ang = 0;
		for (int i = 0; i < CORDIC_ITER; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv >= 0) begin
				xv += dx; yv -= dy; ang += ATAN_STEP[i];
			end else begin
				xv -= dx; yv += dy; ang -= ATAN_STEP[i];
			end
		end
		zm = (magnitude(ang) + 128) >> 8;
		r = (zm > 23040) ? 23040 : longint'(zm);
		return (ang < 0) ? -r : r;
	endfunction

	function automatic longint lever_deviation(longint tsum);
		longint unsigned p, q;
		p = longint'(lever_mm) * magnitude(tsum);
		q = (p * longint'(DEV_SCALE) + (64'd1 << 23)) >> 24;
		if (tsum < 0)
			return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
		return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
	endfunction

	// fold one sample into the window; returns 1 when the window closes
	function automatic bit accumulate_sample(accel_t x, accel_t y, accel_t z,
			output window_result_t res);
		longint s [3];
		int n;
		s[0] = x; s[1] = y; s[2] = z;
		tilt_sum[0] += axis_tilt(s[0], s[1], s[2]);
		tilt_sum[1] += axis_tilt(s[1], s[0], s[2]);
		tilt_sum[2] += axis_tilt(s[2], s[0], s[1]);
		for (int k = 0; k < 3; k++)
			acc_sum[k] += s[k];
		win_count++;
		n = (win_len == 0) ? 1 : ((win_len > MAX_SAMPLES) ? MAX_SAMPLES : win_len);
		if (win_count < n)
			return 1'b0;
		for (int k = 0; k < 3; k++) begin
			res.acc[k]  = 20'(acc_sum[k] / n);
			res.tilt[k] = 16'(tilt_sum[k] / n);
			res.dev[k]  = 32'(lever_deviation(tilt_sum[k]));
			acc_sum[k] = 0;
			tilt_sum[k] = 0;
		end
		win_count = 0;
		return 1'b1;
	endfunction

	task automatic report(string what, longint got, longint want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch %s: got %0d, want %0d (window %0d)",
				what, got, want, windows_seen);
	endtask

	// check each result beat against the oldest pending window
	always @(posedge clk) begin
		window_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			windows_seen++;
			if (pending_windows.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				want = pending_windows.pop_front();
				if (avg_accel_x != want.acc[0]) report("avg_accel_x", avg_accel_x, want.acc[0]);
				if (avg_accel_y != want.acc[1]) report("avg_accel_y", avg_accel_y, want.acc[1]);
				if (avg_accel_z != want.acc[2]) report("avg_accel_z", avg_accel_z, want.acc[2]);
				if (avg_tilt_x != want.tilt[0]) report("avg_tilt_x", avg_tilt_x, want.tilt[0]);
				if (avg_tilt_y != want.tilt[1]) report("avg_tilt_y", avg_tilt_y, want.tilt[1]);
				if (avg_tilt_z != want.tilt[2]) report("avg_tilt_z", avg_tilt_z, want.tilt[2]);
				if (deviation_x != want.dev[0]) report("deviation_x", deviation_x, want.dev[0]);
				if (deviation_y != want.dev[1]) report("deviation_y", deviation_y, want.dev[1]);
				if (deviation_z != want.dev[2]) report("deviation_z", deviation_z, want.dev[2]);
			end
		end
	end

	// watchdog: any accepted beat on either side resets the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d windows pending", pending_windows.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold on request
	initial begin
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else if (idling_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// offer one sample beat and hold it until accepted; valid stays high after
	task automatic send_sample(accel_t x, accel_t y, accel_t z, bit typed_check,
			window_result_t typed);
		window_result_t res;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		do @(posedge clk); while (in_stall);
		samples_sent++;
		if (accumulate_sample(x, y, z, res))
			pending_windows.push_back(typed_check ? typed : res);
	endtask

	// drop valid, wait for every pending window, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_windows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SAMPLES)
			win_len = val[4:0];
		else
			lever_mm = val;
	endtask

	function automatic window_result_t flat_result(accel_t x, accel_t y, accel_t z,
			tilt_t tx, tilt_t ty, tilt_t tz);
		window_result_t r;
		r.acc = '{x, y, z};
		r.tilt = '{tx, ty, tz};
		r.dev = '{0, 0, 0};
		return r;
	endfunction

	function automatic accel_t random_axis();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return accel_t'($urandom_range(0, 1) ? 20'h7FFFF : 20'h80000);
			2: return accel_t'(int'($urandom_range(0, 255)) - 128);
			default: return accel_t'($urandom);
		endcase
	endfunction

	plan_row_t plan[$];
	window_result_t none;

	initial begin
		plan_row_t row;
		int sent;
		int burst;
		logic [15:0] lever_pick;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single-sample windows, special vectors first with zero lever, then max lever
		plan.push_back('{ROW_CFG, 0, 0, 0, CFG_SAMPLES, 16'd1, none});
		plan.push_back('{ROW_CFG, 0, 0, 0, CFG_LEVER, 16'd0, none});
		plan.push_back('{ROW_CHECKED, 0, 0, 0, 0, 0, flat_result(0, 0, 0, 0, 0, 0)});
		plan.push_back('{ROW_CHECKED, 0, 0, 20'sh7FFFF, 0, 0,
			flat_result(0, 0, 20'sh7FFFF, 0, 0, 23040)});
		plan.push_back('{ROW_CHECKED, 0, 0, 20'sh80000, 0, 0,
			flat_result(0, 0, 20'sh80000, 0, 0, -23040)});
		plan.push_back('{ROW_CHECKED, 20'sh7FFFF, 0, 0, 0, 0,
			flat_result(20'sh7FFFF, 0, 0, 23040, 0, 0)});
		plan.push_back('{ROW_CHECKED, 0, 20'sh80000, 0, 0, 0,
			flat_result(0, 20'sh80000, 0, 0, -23040, 0)});
		plan.push_back('{ROW_SAMPLE, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 0, 0, none});
		plan.push_back('{ROW_SAMPLE, 20'sh80000, 20'sh80000, 20'sh80000, 0, 0, none});
		plan.push_back('{ROW_SAMPLE, 1, -1, 1, 0, 0, none});
		plan.push_back('{ROW_CFG, 0, 0, 0, CFG_LEVER, 16'hFFFF, none});
		plan.push_back('{ROW_SAMPLE, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 0, 0, none});
		plan.push_back('{ROW_SAMPLE, 1000, 0, 262144, 0, 0, none});
		// long window with max lever, then a window of zero, acting as one
		plan.push_back('{ROW_CFG, 0, 0, 0, CFG_SAMPLES, 16'd31, none});
		for (int i = 0; i < 16; i++)
			plan.push_back('{ROW_SAMPLE, 20'sh7FFFF, 0, 5, 0, 0, none});
		plan.push_back('{ROW_CFG, 0, 0, 0, CFG_SAMPLES, 16'd0, none});
		plan.push_back('{ROW_SAMPLE, -300000, 123456, -7, 0, 0, none});
		// shorten the window after five samples: next one closes it
		plan.push_back('{ROW_CFG, 0, 0, 0, CFG_SAMPLES, 16'd16, none});
		for (int i = 0; i < 5; i++)
			plan.push_back('{ROW_SAMPLE, 20'(i * 9001), -20'(i * 77), 4096, 0, 0, none});
		plan.push_back('{ROW_CFG, 0, 0, 0, CFG_SAMPLES, 16'd3, none});
		plan.push_back('{ROW_SAMPLE, 17, 18, -19, 0, 0, none});

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_CFG)
				write_reg(row.reg_idx, row.reg_val);
			else
				send_sample(row.x, row.y, row.z, row.kind == ROW_CHECKED, row.typed);
		end

		// random phases, each with its own window and lever
		sent = 0;
		for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
			case (phase % 5)
				0: write_reg(CFG_SAMPLES, 16'd1);
				1: write_reg(CFG_SAMPLES, 16'd16);
				default: write_reg(CFG_SAMPLES, 16'($urandom_range(0, 31)));
			endcase
			case (phase % 4)
				0: lever_pick = 16'hFFFF;
				1: lever_pick = 16'd0;
				default: lever_pick = 16'($urandom);
			endcase
			write_reg(CFG_LEVER, lever_pick);
			// let the result side back up while samples keep coming
			if (phase == 2)
				long_hold = 1'b1;
			if (sent > RANDOM_ITEMS - 200)
				idling_on = 1'b0;
			burst = 60 + int'($urandom_range(0, 60));
			for (int i = 0; i < burst; i++) begin
				send_sample(random_axis(), random_axis(), random_axis(), 1'b0, none);
				sent++;
			end
			// sender waits for the block to empty now and then
			if (phase % 3 == 1)
				drain();
		end

		drain();
		$display("sent %0d samples, checked %0d windows across several window/lever settings",
			samples_sent, windows_seen);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: tilt_angle_averager.f
design/taa_pkg.sv
design/taa_tilt.sv
design/tilt_angle_averager.sv
tb/sv/tilt_angle_averager_tb.sv
